### hw/rtl/selective_repeat_sender_window_unit_macros.svh
// Assertion helpers shared by the sender window modules.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRSW_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sender window check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRSW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sender window check failed");

`endif

### hw/rtl/srsw_pkg.sv
package srsw_pkg;

  localparam int OpW     = 2;
  localparam int StatusW = 3;
  localparam int WinW    = 4;
  localparam int RetryW  = 8;
  localparam int DataW   = 32;
  localparam int AddrW   = 3;

  localparam logic [WinW-1:0]   WindowLimit  = 4'd8;
  localparam logic [WinW-1:0]   WindowReset  = 4'd4;
  localparam logic [RetryW-1:0] RetriesReset = 8'd10;
  localparam logic [RetryW-1:0] RetryMax     = 8'd255;

  localparam logic [0:0] RegWindow  = 1'b0;
  localparam logic [0:0] RegRetries = 1'b1;

  localparam logic [OpW-1:0] OpNew     = 2'd0;
  localparam logic [OpW-1:0] OpEnd     = 2'd1;
  localparam logic [OpW-1:0] OpAck     = 2'd2;
  localparam logic [OpW-1:0] OpTimeout = 2'd3;

  localparam logic [StatusW-1:0] StSent     = 3'd0;
  localparam logic [StatusW-1:0] StRefused  = 3'd1;
  localparam logic [StatusW-1:0] StAckTaken = 3'd2;
  localparam logic [StatusW-1:0] StIgnored  = 3'd3;
  localparam logic [StatusW-1:0] StResent   = 3'd4;
  localparam logic [StatusW-1:0] StHalted   = 3'd5;
  localparam logic [StatusW-1:0] StFinished = 3'd6;
  localparam logic [StatusW-1:0] StEndNoted = 3'd7;

  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_go;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/srsw_in_if.sv
interface srsw_in_if #(
  parameter int SeqW = 4
) ();
  import srsw_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [SeqW-1:0]  seq;
  logic             ack_intact;

  modport source (output valid, opcode, seq, ack_intact, input ready);
  modport sink   (input valid, opcode, seq, ack_intact, output ready);
endinterface

### hw/rtl/srsw_out_if.sv
interface srsw_out_if #(
  parameter int SeqW = 4
) ();
  import srsw_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SeqW-1:0]    seq_out;
  logic               transmit;
  logic               start_timer;
  logic               stop_timer;
  logic [SeqW-1:0]    window_base_out;
  logic [SeqW-1:0]    next_seq_out;
  logic [RetryW-1:0]  retry_count_out;

  modport source (output valid, status, seq_out, transmit, start_timer, stop_timer,
                  window_base_out, next_seq_out, retry_count_out, input ready);
  modport sink   (input valid, status, seq_out, transmit, start_timer, stop_timer,
                  window_base_out, next_seq_out, retry_count_out, output ready);
endinterface

### hw/rtl/selective_repeat_sender_window_unit.sv
// Channel  Direction  Carries
// req_i    in         opcode, seq, ack_intact
// res_o    out        status, seq_out, transmit, start_timer, stop_timer,
//                     window_base_out, next_seq_out, retry_count_out
// apb      in/out     window_size at 0x0, max_retries at 0x4
//
// A request passes through the accept, execute and emit steps; its result is loaded into
// the output register at the emit step.
// An intact acknowledgement of the window base adds walk steps, in which the base slides
// over early-acknowledged numbers, up to the effective window size (at most 8).
// The base slide uses one bitmap lookup per cycle. A new request is taken while the
// previous result still waits; a stalled result holds the block before its next result.
// Reset clears the window, the bitmap and the protocol flags at once; no clearing pass.
module selective_repeat_sender_window_unit #(
  parameter int SEQ_SPACE = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  srsw_in_if.sink                     req_i,
  srsw_out_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsw_pkg::AddrW-1:0]  paddr,
  input  logic [srsw_pkg::DataW-1:0]  pwdata,
  output logic [srsw_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import srsw_pkg::*;

  localparam int SeqW = $clog2(SEQ_SPACE);

  cmd_t              cmd;
  sts_t              sts;
  logic [WinW-1:0]   window_size;
  logic [RetryW-1:0] max_retries;

  srsw_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_size_o (window_size),
    .max_retries_o (max_retries)
  );

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srsw_dpath #(
    .SEQ_SPACE (SEQ_SPACE),
    .SeqW      (SeqW)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .window_size_i     (window_size),
    .max_retries_i     (max_retries),
    .opcode_i          (req_i.opcode),
    .seq_i             (req_i.seq),
    .ack_intact_i      (req_i.ack_intact),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .status_o          (res_o.status),
    .seq_out_o         (res_o.seq_out),
    .transmit_o        (res_o.transmit),
    .start_timer_o     (res_o.start_timer),
    .stop_timer_o      (res_o.stop_timer),
    .window_base_out_o (res_o.window_base_out),
    .next_seq_out_o    (res_o.next_seq_out),
    .retry_count_out_o (res_o.retry_count_out)
  );

endmodule

### hw/rtl/srsw_regs.sv
module srsw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsw_pkg::AddrW-1:0]    paddr,
  input  logic [srsw_pkg::DataW-1:0]    pwdata,
  output logic [srsw_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output logic [srsw_pkg::WinW-1:0]     window_size_o,
  output logic [srsw_pkg::RetryW-1:0]   max_retries_o
);
  import srsw_pkg::*;

  logic [WinW-1:0]   window_size_q, window_size_d;
  logic [RetryW-1:0] max_retries_q, max_retries_d;
  logic              wr_en;
  logic [0:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:AddrW-1];

  always_comb begin
    window_size_d = window_size_q;
    max_retries_d = max_retries_q;
    if (wr_en) begin
      case (reg_idx)
        RegWindow:  window_size_d = pwdata[WinW-1:0];
        RegRetries: max_retries_d = pwdata[RetryW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWindow:  prdata = DataW'(window_size_q);
      RegRetries: prdata = DataW'(max_retries_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WindowReset;
      max_retries_q <= RetriesReset;
    end else begin
      window_size_q <= window_size_d;
      max_retries_q <= max_retries_d;
    end
  end

  assign window_size_o = window_size_q;
  assign max_retries_o = max_retries_q;

endmodule

### hw/rtl/srsw_ctrl.sv
`include "selective_repeat_sender_window_unit_macros.svh"

module srsw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  srsw_pkg::sts_t sts_i,
  output srsw_pkg::cmd_t cmd_o
);
  import srsw_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SWalk = 2'd2;
  localparam logic [1:0] SEmit = 2'd3;

  logic [1:0] state_q, state_d;
  logic [3:0] cmd_vec;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SExec;
        end
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_walk ? SWalk : SEmit;
      end
      SWalk: begin
        cmd_o.walk = 1'b1;
        if (!sts_i.walk_go) begin
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_vec = {cmd_o.capture, cmd_o.exec, cmd_o.walk, cmd_o.emit};

  `SRSW_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd_vec))
  `SRSW_ASSERT_NEXT(a_accept_exec, in_valid_i && in_ready_o, state_q == SExec)
  `SRSW_ASSERT_SAME(a_walk_entry, state_q == SWalk,
                    $past(state_q) == SExec || $past(state_q) == SWalk)

endmodule

### hw/rtl/srsw_dpath.sv
`include "selective_repeat_sender_window_unit_macros.svh"

module srsw_dpath #(
  parameter int SEQ_SPACE = 16,
  parameter int SeqW      = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srsw_pkg::cmd_t                 cmd_i,
  output srsw_pkg::sts_t                 sts_o,
  input  logic [srsw_pkg::WinW-1:0]      window_size_i,
  input  logic [srsw_pkg::RetryW-1:0]    max_retries_i,
  input  logic [srsw_pkg::OpW-1:0]       opcode_i,
  input  logic [SeqW-1:0]                seq_i,
  input  logic                           ack_intact_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [srsw_pkg::StatusW-1:0]   status_o,
  output logic [SeqW-1:0]                seq_out_o,
  output logic                           transmit_o,
  output logic                           start_timer_o,
  output logic                           stop_timer_o,
  output logic [SeqW-1:0]                window_base_out_o,
  output logic [SeqW-1:0]                next_seq_out_o,
  output logic [srsw_pkg::RetryW-1:0]    retry_count_out_o
);
  import srsw_pkg::*;

  localparam int CmpW = (SeqW > WinW) ? SeqW : WinW;
  localparam int WinCapI = (8 < SEQ_SPACE - 1) ? 8 : SEQ_SPACE - 1;
  localparam logic [WinW-1:0] WinCap = WinCapI[WinW-1:0];
  localparam logic [SeqW:0] SpaceW = SEQ_SPACE[SeqW:0];
  localparam logic [SeqW-1:0] SeqLast = SEQ_SPACE'(SEQ_SPACE - 1) > 0 ?
                                        SeqW'(SEQ_SPACE - 1) : '0;

  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] v);
    return (v == SeqLast) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [SeqW-1:0] seq_dist(input logic [SeqW-1:0] from,
                                               input logic [SeqW-1:0] to);
    logic [SeqW:0] wide;
    wide = {1'b0, to} + SpaceW - {1'b0, from};
    return (to >= from) ? (to - from) : wide[SeqW-1:0];
  endfunction

  // Protocol state.
  logic [SeqW-1:0]      base_q, base_d, next_q, next_d;
  logic [SEQ_SPACE-1:0] early_q, early_d;
  logic [RetryW-1:0]    rc_q, rc_d;
  logic                 drain_q, drain_d, ended_q, ended_d, halted_q, halted_d;

  // Captured request and the result under construction.
  logic [OpW-1:0]       op_q, op_d;
  logic [SeqW-1:0]      seq_q, seq_d;
  logic                 intact_q, intact_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic [SeqW-1:0]      res_seq_q, res_seq_d;
  logic                 res_tx_q, res_tx_d, res_st_q, res_st_d, res_sp_q, res_sp_d;
  logic [WinW-1:0]      walk_cnt_q, walk_cnt_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   o_status_q, o_status_d;
  logic [SeqW-1:0]      o_seq_q, o_seq_d, o_base_q, o_base_d, o_next_q, o_next_d;
  logic                 o_tx_q, o_tx_d, o_st_q, o_st_d, o_sp_q, o_sp_d;
  logic [RetryW-1:0]    o_rc_q, o_rc_d;

  logic [WinW-1:0]      win_eff;
  logic [SeqW-1:0]      outst;
  logic                 seq_ok, seq_outst, seq_early, finished, room;
  logic [RetryW-1:0]    rc_inc;

  always_comb begin
    if (window_size_i == '0) begin
      win_eff = WinW'(1);
    end else if (window_size_i > WinCap) begin
      win_eff = WinCap;
    end else begin
      win_eff = window_size_i;
    end
  end

  assign outst     = seq_dist(base_q, next_q);
  assign seq_ok    = {1'b0, seq_q} < SpaceW;
  assign seq_outst = seq_ok && (seq_dist(base_q, seq_q) < outst);
  assign seq_early = seq_ok && early_q[seq_q];
  assign finished  = ended_q && (outst == '0);
  assign room      = CmpW'(outst) < CmpW'(win_eff);
  assign rc_inc    = (rc_q == RetryMax) ? RetryMax : rc_q + 1'b1;

  assign sts_o.need_walk = !halted_q && !finished && (op_q == OpAck) && intact_q &&
                           seq_outst && (seq_q == base_q);
  assign sts_o.walk_go   = (walk_cnt_q < win_eff) && (base_q != next_q) && early_q[base_q];
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    base_d       = base_q;
    next_d       = next_q;
    early_d      = early_q;
    rc_d         = rc_q;
    drain_d      = drain_q;
    ended_d      = ended_q;
    halted_d     = halted_q;
    op_d         = op_q;
    seq_d        = seq_q;
    intact_d     = intact_q;
    res_status_d = res_status_q;
    res_seq_d    = res_seq_q;
    res_tx_d     = res_tx_q;
    res_st_d     = res_st_q;
    res_sp_d     = res_sp_q;
    walk_cnt_d   = walk_cnt_q;
    out_valid_d  = out_valid_q;
    o_status_d   = o_status_q;
    o_seq_d      = o_seq_q;
    o_tx_d       = o_tx_q;
    o_st_d       = o_st_q;
    o_sp_d       = o_sp_q;
    o_base_d     = o_base_q;
    o_next_d     = o_next_q;
    o_rc_d       = o_rc_q;

    if (cmd_i.capture) begin
      op_d     = opcode_i;
      seq_d    = seq_i;
      intact_d = ack_intact_i;
    end

    if (cmd_i.exec) begin
      res_seq_d  = '0;
      res_tx_d   = 1'b0;
      res_st_d   = 1'b0;
      res_sp_d   = 1'b0;
      walk_cnt_d = '0;
      if (halted_q) begin
        res_status_d = StHalted;
      end else if (finished) begin
        res_status_d = StFinished;
      end else begin
        case (op_q)
          OpNew: begin
            if (!drain_q && !ended_q && room) begin
              res_status_d    = StSent;
              res_seq_d       = next_q;
              res_tx_d        = 1'b1;
              res_st_d        = 1'b1;
              early_d[next_q] = 1'b0;
              next_d          = seq_inc(next_q);
            end else begin
              res_status_d = StRefused;
              if (!room) begin
                drain_d = 1'b1;
              end
            end
          end
          OpEnd: begin
            ended_d      = 1'b1;
            drain_d      = 1'b1;
            res_status_d = (outst == '0) ? StFinished : StEndNoted;
          end
          OpAck: begin
            rc_d      = '0;
            res_seq_d = seq_q;
            if (intact_q && seq_outst) begin
              res_status_d = StAckTaken;
              res_sp_d     = 1'b1;
              if (seq_q == base_q) begin
                base_d = seq_inc(base_q);
              end else begin
                early_d[seq_q] = 1'b1;
              end
            end else begin
              res_status_d = StIgnored;
            end
          end
          OpTimeout: begin
            res_seq_d = seq_q;
            if (seq_outst && !seq_early) begin
              res_status_d = StResent;
              res_tx_d     = 1'b1;
              res_st_d     = 1'b1;
              rc_d         = rc_inc;
              if (rc_inc >= max_retries_i) begin
                halted_d     = 1'b1;
                res_status_d = StHalted;
              end
            end else begin
              res_status_d = StIgnored;
            end
          end
          default: res_status_d = StIgnored;
        endcase
      end
    end

    if (cmd_i.walk) begin
      if (sts_o.walk_go) begin
        early_d[base_q] = 1'b0;
        base_d          = seq_inc(base_q);
        walk_cnt_d      = walk_cnt_q + 1'b1;
      end else if (base_q == next_q) begin
        drain_d = 1'b0;
        if (ended_q) begin
          res_status_d = StFinished;
        end
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      o_status_d  = res_status_q;
      o_seq_d     = res_seq_q;
      o_tx_d      = res_tx_q;
      o_st_d      = res_st_q;
      o_sp_d      = res_sp_q;
      o_base_d    = base_q;
      o_next_d    = next_q;
      o_rc_d      = rc_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      early_q     <= '0;
      rc_q        <= '0;
      drain_q     <= 1'b0;
      ended_q     <= 1'b0;
      halted_q    <= 1'b0;
      walk_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      next_q      <= next_d;
      early_q     <= early_d;
      rc_q        <= rc_d;
      drain_q     <= drain_d;
      ended_q     <= ended_d;
      halted_q    <= halted_d;
      walk_cnt_q  <= walk_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    seq_q        <= seq_d;
    intact_q     <= intact_d;
    res_status_q <= res_status_d;
    res_seq_q    <= res_seq_d;
    res_tx_q     <= res_tx_d;
    res_st_q     <= res_st_d;
    res_sp_q     <= res_sp_d;
    o_status_q   <= o_status_d;
    o_seq_q      <= o_seq_d;
    o_tx_q       <= o_tx_d;
    o_st_q       <= o_st_d;
    o_sp_q       <= o_sp_d;
    o_base_q     <= o_base_d;
    o_next_q     <= o_next_d;
    o_rc_q       <= o_rc_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign seq_out_o         = o_seq_q;
  assign transmit_o        = o_tx_q;
  assign start_timer_o     = o_st_q;
  assign stop_timer_o      = o_sp_q;
  assign window_base_out_o = o_base_q;
  assign next_seq_out_o    = o_next_q;
  assign retry_count_out_o = o_rc_q;

  `SRSW_ASSERT_SAME(a_walk_bound, cmd_i.walk, walk_cnt_q <= win_eff)
  `SRSW_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `SRSW_ASSERT_NEXT(a_emit_valid, cmd_i.emit, out_valid_q)

endmodule

### tb/selective_repeat_sender_window_unit_tb.sv
`timescale 1ns / 1ps

module selective_repeat_sender_window_unit_tb;
  import srsw_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 7;
  localparam int SettleCycles = 20;
  localparam int MaxGap       = 24;
  localparam int PhaseItems   = 200;
  localparam int HoldCycles   = 300;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [3:0]         seq_out;
    logic               transmit;
    logic               start_timer;
    logic               stop_timer;
    logic [3:0]         base;
    logic [3:0]         next;
    logic [RetryW-1:0]  retries;
  } window_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  srsw_in_if  #(.SeqW(4)) req_if ();
  srsw_out_if #(.SeqW(4)) res_if ();

  selective_repeat_sender_window_unit #(.SEQ_SPACE(16)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow of the sender window.
  logic [3:0]        cfg_window;
  logic [RetryW-1:0] cfg_retries;
  logic [3:0]        win_base;
  logic [3:0]        next_num;
  logic [15:0]       early_map;
  logic [RetryW-1:0] retry_cnt;
  logic              drain_on;
  logic              data_done;
  logic              is_halted;

  window_result_t expected_results[$];
  int             err_count;
  int             tx_idle_pct;
  int             rx_stall_pct;
  int             hold_left;

  function automatic window_result_t predict_window_step(logic [OpW-1:0] op, logic [3:0] sq,
                                                         logic intact);
    window_result_t r;
    logic [3:0]     w;
    logic [3:0]     outst;
    logic [3:0]     rel_pos;
    logic           in_window;
    int             n;
    r = '0;
    if (cfg_window == 4'd0) w = 4'd1;
    else if (cfg_window > WindowLimit) w = WindowLimit;
    else w = cfg_window;
    outst = next_num - win_base;
    rel_pos = sq - win_base;
    in_window = rel_pos < outst;
    if (is_halted) begin
      r.status = StHalted;
    end else if (data_done && outst == 4'd0) begin
      r.status = StFinished;
    end else begin
      case (op)
        OpNew: begin
          if (!drain_on && !data_done && outst < w) begin
            r.status = StSent;
            r.seq_out = next_num;
            r.transmit = 1'b1;
            r.start_timer = 1'b1;
            early_map[next_num] = 1'b0;
            next_num = next_num + 4'd1;
          end else begin
            r.status = StRefused;
            if (outst >= w) drain_on = 1'b1;
          end
        end
        OpEnd: begin
          data_done = 1'b1;
          drain_on = 1'b1;
          r.status = (outst == 4'd0) ? StFinished : StEndNoted;
        end
        OpAck: begin
          retry_cnt = '0;
          r.seq_out = sq;
          if (intact && in_window) begin
            r.status = StAckTaken;
            r.stop_timer = 1'b1;
            if (sq == win_base) begin
              n = 0;
              win_base = win_base + 4'd1;
              while (n < w && win_base != next_num && early_map[win_base]) begin
                early_map[win_base] = 1'b0;
                win_base = win_base + 4'd1;
                n++;
              end
            end else begin
              early_map[sq] = 1'b1;
            end
            if (win_base == next_num) begin
              drain_on = 1'b0;
              if (data_done) r.status = StFinished;
            end
          end else begin
            r.status = StIgnored;
          end
        end
        default: begin
          r.seq_out = sq;
          if (in_window && !early_map[sq]) begin
            r.status = StResent;
            r.transmit = 1'b1;
            r.start_timer = 1'b1;
            if (retry_cnt != RetryMax) retry_cnt = retry_cnt + 8'd1;
            if (retry_cnt >= cfg_retries) begin
              is_halted = 1'b1;
              r.status = StHalted;
            end
          end else begin
            r.status = StIgnored;
          end
        end
      endcase
    end
    r.base = win_base;
    r.next = next_num;
    r.retries = retry_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch in %0s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : result_monitor
    window_result_t seen;
    window_result_t due;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen.status      = res_if.status;
        seen.seq_out     = res_if.seq_out;
        seen.transmit    = res_if.transmit;
        seen.start_timer = res_if.start_timer;
        seen.stop_timer  = res_if.stop_timer;
        seen.base        = res_if.window_base_out;
        seen.next        = res_if.next_seq_out;
        seen.retries     = res_if.retry_count_out;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          due = expected_results.pop_front();
          if (seen.status !== due.status) report_mismatch("status", seen.status, due.status);
          if (seen.seq_out !== due.seq_out)
            report_mismatch("seq_out", seen.seq_out, due.seq_out);
          if (seen.transmit !== due.transmit)
            report_mismatch("transmit", seen.transmit, due.transmit);
          if (seen.start_timer !== due.start_timer)
            report_mismatch("start_timer", seen.start_timer, due.start_timer);
          if (seen.stop_timer !== due.stop_timer)
            report_mismatch("stop_timer", seen.stop_timer, due.stop_timer);
          if (seen.base !== due.base)
            report_mismatch("window_base_out", seen.base, due.base);
          if (seen.next !== due.next)
            report_mismatch("next_seq_out", seen.next, due.next);
          if (seen.retries !== due.retries)
            report_mismatch("retry_count_out", seen.retries, due.retries);
        end
      end
      if (req_if.valid && req_if.ready)
        expected_results.push_back(predict_window_step(req_if.opcode, req_if.seq,
                                                       req_if.ack_intact));
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (rx_stall_pct != 0) begin
      res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic apb_access(logic [0:0] idx, logic wr, logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(logic [0:0] idx, logic [DataW-1:0] value);
    logic [DataW-1:0] unused;
    apb_access(idx, 1'b1, value, unused);
    if (idx == RegWindow) cfg_window = value[3:0];
    else cfg_retries = value[RetryW-1:0];
  endtask

  task automatic check_register(logic [0:0] idx);
    logic [DataW-1:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    if (idx == RegWindow) begin
      if (rdata[3:0] !== cfg_window) report_mismatch("window_size readback", rdata[3:0],
                                                     cfg_window);
    end else begin
      if (rdata[RetryW-1:0] !== cfg_retries)
        report_mismatch("max_retries readback", rdata[RetryW-1:0], cfg_retries);
    end
  endtask

  task automatic configure(logic [3:0] window, logic [RetryW-1:0] retries);
    write_register(RegWindow, {{(DataW-4){1'b0}}, window});
    write_register(RegRetries, {{(DataW-RetryW){1'b0}}, retries});
    check_register(RegWindow);
    check_register(RegRetries);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin tx_idle_pct = 57; rx_stall_pct = 0; end
      2: begin tx_idle_pct = 0; rx_stall_pct = 57; end
      3: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  task automatic send_request(logic [OpW-1:0] op, logic [3:0] sq, logic intact);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.seq        <= sq;
    req_if.ack_intact <= intact;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Acks and timeouts mostly name numbers inside the current window so that
  // the window keeps moving and early acks pile up.
  task automatic send_random(int count, int pct_new, int pct_ack, int pct_end);
    logic [OpW-1:0] op;
    logic [3:0]     sq;
    logic [3:0]     span;
    int             r;
    repeat (count) begin
      r = $urandom_range(99);
      span = next_num - win_base;
      if (r < pct_new) op = OpNew;
      else if (r < pct_new + pct_ack) op = OpAck;
      else if (r < pct_new + pct_ack + pct_end) op = OpEnd;
      else op = OpTimeout;
      if (span != 4'd0 && $urandom_range(99) < 80) sq = win_base + 4'($urandom_range(span - 1));
      else sq = 4'($urandom_range(15));
      send_request(op, sq, $urandom_range(99) < 90);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_register_reset();
    check_register(RegWindow);
    check_register(RegRetries);
  endtask

  task automatic test_directed_window();
    send_request(OpAck, 4'd15, 1'b1);
    send_request(OpTimeout, 4'd0, 1'b1);
    repeat (4) send_request(OpNew, 4'd0, 1'b0);
    send_request(OpNew, 4'd15, 1'b1);
    send_request(OpNew, 4'd0, 1'b0);
    send_request(OpAck, 4'd2, 1'b1);
    send_request(OpAck, 4'd1, 1'b0);
    send_request(OpTimeout, 4'd2, 1'b0);
    send_request(OpTimeout, 4'd1, 1'b1);
    send_request(OpTimeout, 4'd3, 1'b1);
    send_request(OpAck, 4'd1, 1'b1);
    send_request(OpAck, 4'd0, 1'b1);
    send_request(OpAck, 4'd3, 1'b1);
    send_request(OpNew, 4'd0, 1'b0);
    send_request(OpAck, 4'd15, 1'b1);
    send_request(OpAck, 4'd4, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned windows[8] = '{1, 8, 0, 15, 4, 2, 0, 0};
    int unsigned limits[8]  = '{255, 128, 40, 255, 200, 85, 0, 0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) begin
        windows[ph] = $urandom_range(15);
        limits[ph] = $urandom_range(255, 20);
      end
      set_idling(ph % 4);
      configure(4'(windows[ph]), 8'(limits[ph]));
      send_random(PhaseItems, 40, 40, 0);
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    set_idling(0);
    configure(4'd8, 8'd255);
    @(posedge clk_i);
    hold_left = HoldCycles;
    send_random(40, 50, 35, 0);
    wait_idle();
  endtask

  // Reaching the end of data or halting is permanent, so this test closes the run; the end
  // of data is always sent, and a random choice sets a low retry limit so the block may halt.
  task automatic test_end_of_data();
    logic              halt_path;
    logic [RetryW-1:0] limit;
    halt_path = 1'($urandom_range(1));
    case ($urandom_range(2))
      0: limit = 8'd0;
      1: limit = 8'd1;
      default: limit = 8'd3;
    endcase
    set_idling(3);
    configure(4'd8, halt_path ? limit : RetryMax);
    repeat (3) send_request(OpNew, 4'($urandom_range(15)), 1'($urandom_range(1)));
    send_request(OpEnd, 4'($urandom_range(15)), 1'($urandom_range(1)));
    if (halt_path) send_random(60, 10, 10, 10);
    else send_random(60, 10, 70, 10);
  endtask

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.opcode     = OpNew;
    req_if.seq        = '0;
    req_if.ack_intact = 1'b0;
    res_if.ready      = 1'b0;
    err_count         = 0;
    hold_left         = 0;
    cfg_window        = WindowReset;
    cfg_retries       = RetriesReset;
    win_base          = '0;
    next_num          = '0;
    early_map         = '0;
    retry_cnt         = '0;
    drain_on          = 1'b0;
    data_done         = 1'b0;
    is_halted         = 1'b0;
    set_idling(0);
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_directed_window();
    test_random_traffic();
    test_output_backpressure();
    test_end_of_data();

    set_idling(0);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    for (int k = 0; k < 5000 && expected_results.size() != 0; k++) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results still expected", 0, expected_results.size());
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_in_if.sv
hw/rtl/srsw_out_if.sv
hw/rtl/srsw_regs.sv
hw/rtl/srsw_ctrl.sv
hw/rtl/srsw_dpath.sv
hw/rtl/selective_repeat_sender_window_unit.sv
tb/selective_repeat_sender_window_unit_tb.sv
